### rtl/zero_sync_motor_command_deframer_core_macros.svh
// ----------------------------------------------------------------------------
// zero_sync_motor_command_deframer_core_macros
// Assertion macros shared by the deframer checker.
// ----------------------------------------------------------------------------
`ifndef ZERO_SYNC_MOTOR_COMMAND_DEFRAMER_CORE_MACROS_SVH
`define ZERO_SYNC_MOTOR_COMMAND_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ZSMD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("deframer check failed");

// Next-cycle implication, off while reset is held.
`define ZSMD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("deframer check failed");

`endif

### rtl/zsmd_pkg.sv
// ----------------------------------------------------------------------------
// zsmd_pkg
// Shared types and constants of the zero-sync motor command deframer.
// ----------------------------------------------------------------------------
package zsmd_pkg;

    localparam int FRAME_BYTES = 10;
    // Bytes kept in the frame store; the check byte is compared on arrival.
    localparam int STORE_BYTES = FRAME_BYTES - 1;
    localparam int IDX_W       = $clog2(STORE_BYTES);
    localparam int CNT_W       = 4;

    localparam int EVENT_W  = 2;
    localparam int PERIOD_W = 16;
    localparam int DIR_W    = 4;

    typedef logic [7:0] t_byte;

    typedef enum logic [1:0] {
        PH_WAIT   = 2'd0,
        PH_FIRST  = 2'd1,
        PH_SECOND = 2'd2,
        PH_FRAME  = 2'd3
    } t_phase;

    typedef enum logic [EVENT_W-1:0] {
        EV_ACCEPT    = 2'd0,
        EV_CHECK_ERR = 2'd1,
        EV_LINK_LOST = 2'd2
    } t_event;

    typedef struct packed {
        t_event              ev;
        logic [PERIOD_W-1:0] period_a;
        logic [PERIOD_W-1:0] period_b;
        logic [PERIOD_W-1:0] period_c;
        logic [PERIOD_W-1:0] period_d;
        logic [DIR_W-1:0]    dir;
    } t_result;

endpackage

### rtl/zsmd_front.sv
// ----------------------------------------------------------------------------
// zsmd_front
// Byte classifier, frame assembler and link watchdog; emits result words.
// ----------------------------------------------------------------------------
module zsmd_front
    import zsmd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_accept,
    input  logic    i_action,
    input  t_byte   i_data_byte,
    output logic    o_res_valid,
    output t_result o_res
);

    t_phase             r_phase, n_phase;
    logic [CNT_W-1:0]   r_count, n_count;
    t_byte              r_xor, n_xor;
    logic               r_link, n_link;
    logic               r_alive, n_alive;
    logic               r_halted, n_halted;
    t_byte              r_frame [STORE_BYTES];

    logic               w_store_en;
    logic [IDX_W-1:0]   w_store_idx;
    logic               w_zero;
    logic               w_last;
    logic               w_check_ok;
    logic               w_live;

    assign w_live      = i_accept && !r_halted;
    assign w_zero      = (i_data_byte == 8'h00);
    assign w_last      = (r_phase == PH_FRAME) && (r_count == CNT_W'(STORE_BYTES));
    assign w_check_ok  = (i_data_byte == r_xor);
    assign w_store_idx = (r_phase == PH_FRAME) ? r_count[IDX_W-1:0] : '0;

    // next state
    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_xor      = r_xor;
        n_link     = r_link;
        n_alive    = r_alive;
        n_halted   = r_halted;
        w_store_en = 1'b0;
        if (w_live) begin
            if (i_action) begin
                if (r_link) begin
                    if (!r_alive) begin
                        n_halted = 1'b1;
                    end else begin
                        n_alive = 1'b0;
                    end
                end
            end else begin
                n_link = 1'b1;
                case (r_phase)
                    PH_WAIT: begin
                        if (w_zero) begin
                            n_phase = PH_FIRST;
                        end
                    end
                    PH_FIRST: begin
                        n_phase = w_zero ? PH_SECOND : PH_WAIT;
                    end
                    PH_SECOND: begin
                        if (!w_zero) begin
                            n_phase    = PH_FRAME;
                            n_count    = CNT_W'(1);
                            n_xor      = i_data_byte;
                            w_store_en = 1'b1;
                        end
                    end
                    PH_FRAME: begin
                        if (w_last) begin
                            n_phase = PH_WAIT;
                            n_count = '0;
                            if (w_check_ok) begin
                                n_alive = 1'b1;
                            end
                        end else begin
                            n_count    = r_count + CNT_W'(1);
                            n_xor      = r_xor ^ i_data_byte;
                            w_store_en = 1'b1;
                        end
                    end
                    default: begin
                        n_phase = PH_WAIT;
                    end
                endcase
            end
        end
    end

    // result word
    always_comb begin
        o_res_valid     = 1'b0;
        o_res.ev        = EV_ACCEPT;
        o_res.period_a  = {r_frame[2], r_frame[1]};
        o_res.period_b  = {r_frame[4], r_frame[3]};
        o_res.period_c  = {r_frame[6], r_frame[5]};
        o_res.period_d  = {r_frame[8], r_frame[7]};
        o_res.dir       = r_frame[0][DIR_W-1:0];
        if (w_live) begin
            if (i_action) begin
                if (r_link && !r_alive) begin
                    o_res_valid = 1'b1;
                    o_res.ev    = EV_LINK_LOST;
                end
            end else if (w_last) begin
                o_res_valid = 1'b1;
                o_res.ev    = w_check_ok ? EV_ACCEPT : EV_CHECK_ERR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_WAIT;
            r_count  <= '0;
            r_link   <= 1'b0;
            r_alive  <= 1'b0;
            r_halted <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_count  <= n_count;
            r_link   <= n_link;
            r_alive  <= n_alive;
            r_halted <= n_halted;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xor <= n_xor;
        if (w_store_en) begin
            r_frame[w_store_idx] <= i_data_byte;
        end
    end

endmodule

### rtl/zsmd_fifo.sv
// ----------------------------------------------------------------------------
// zsmd_fifo
// Small result queue between the classifier and the output stage.
// ----------------------------------------------------------------------------
module zsmd_fifo
    import zsmd_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_wdata,
    output logic    o_full,
    input  logic    i_pop,
    output t_result o_rdata,
    output logic    o_empty
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_result            r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wptr, n_wptr;
    logic [PTR_W-1:0]   r_rptr, n_rptr;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               w_wr;
    logic               w_rd;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_rdata = r_mem[r_rptr];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && !o_empty;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (w_wr) begin
            n_wptr = (r_wptr == PTR_W'(DEPTH - 1)) ? '0 : r_wptr + PTR_W'(1);
        end
        if (w_rd) begin
            n_rptr = (r_rptr == PTR_W'(DEPTH - 1)) ? '0 : r_rptr + PTR_W'(1);
        end
        if (w_wr && !w_rd) begin
            n_cnt = r_cnt + CNT_W'(1);
        end else if (w_rd && !w_wr) begin
            n_cnt = r_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

endmodule

### rtl/zsmd_back.sv
// ----------------------------------------------------------------------------
// zsmd_back
// Output stage: pulls queued results, clears payload of fault events.
// ----------------------------------------------------------------------------
module zsmd_back
    import zsmd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_result             i_head,
    input  logic                i_head_valid,
    output logic                o_take,
    input  logic                i_pop,
    output logic                o_empty,
    output logic [EVENT_W-1:0]  o_event_res,
    output logic [PERIOD_W-1:0] o_period_a,
    output logic [PERIOD_W-1:0] o_period_b,
    output logic [PERIOD_W-1:0] o_period_c,
    output logic [PERIOD_W-1:0] o_period_d,
    output logic [DIR_W-1:0]    o_direction_bits
);

    logic    r_valid, n_valid;
    t_result r_out, n_out;

    assign o_take = i_head_valid && (!r_valid || i_pop);

    always_comb begin
        n_valid = r_valid;
        n_out   = r_out;
        if (o_take) begin
            n_valid = 1'b1;
            n_out   = i_head;
            if (i_head.ev != EV_ACCEPT) begin
                n_out.period_a = '0;
                n_out.period_b = '0;
                n_out.period_c = '0;
                n_out.period_d = '0;
                n_out.dir      = '0;
            end
        end else if (i_pop) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    assign o_empty          = !r_valid;
    assign o_event_res      = r_out.ev;
    assign o_period_a       = r_out.period_a;
    assign o_period_b       = r_out.period_b;
    assign o_period_c       = r_out.period_c;
    assign o_period_d       = r_out.period_d;
    assign o_direction_bits = r_out.dir;

endmodule

### rtl/zero_sync_motor_command_deframer_core.sv
// ----------------------------------------------------------------------------
// zero_sync_motor_command_deframer_core
// Motor command deframer with zero-byte preamble sync and link watchdog.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue side: push/full. Each word is a link byte (i_action = 0) or a
//   watchdog tick (i_action = 1). Accepted when push is high and full is low.
//   Output queue side: empty/pop. The oldest result sits on the o_ ports while
//   empty is low and leaves on a cycle with pop high.
//   Two or more zero bytes sync; the next nonzero byte opens a 10-byte frame.
//   The tenth byte closes it with one result: command accepted (periods and
//   directions) or check mismatch. A tick after link traffic with no good
//   frame since the previous tick gives one shutdown result and halts.
// Result path: written to the queue at the accepting edge, then loaded into
//   the output register from the queue head when free (empty or popped).
// Throughput: 1 word per cycle on both sides (in while full is low, out
//   while results are queued); set by the one-word-per-cycle result queue.
// Reset: sync active-low; clears sync state, watchdog, halt and the queue.
//   The frame store is not cleared; each frame rewrites what it reads.
// Receiver stall: results pile up in the QUEUE_DEPTH-entry queue plus the
//   output register; full rises only once the queue is full.
// ----------------------------------------------------------------------------
module zero_sync_motor_command_deframer_core
    import zsmd_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // input queue side
    input  logic                push,
    output logic                full,
    input  logic                i_action,
    input  logic [7:0]          i_data_byte,
    // result queue side
    output logic                empty,
    input  logic                pop,
    output logic [EVENT_W-1:0]  o_event_res,
    output logic [PERIOD_W-1:0] o_period_a,
    output logic [PERIOD_W-1:0] o_period_b,
    output logic [PERIOD_W-1:0] o_period_c,
    output logic [PERIOD_W-1:0] o_period_d,
    output logic [DIR_W-1:0]    o_direction_bits
);

    logic    w_accept;
    logic    w_res_valid;
    t_result w_res;
    t_result w_head;
    logic    w_q_empty;
    logic    w_take;

    // Full only depends on queue occupancy, so an accepted word can always
    // drop its result (if any) into the queue in the same cycle.
    assign w_accept = push && !full;

    // Front: sync hunt, frame assembly, running XOR, watchdog.
    zsmd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_action    (i_action),
        .i_data_byte (i_data_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Decoupling queue between front and output stage.
    zsmd_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_wdata (w_res),
        .o_full  (full),
        .i_pop   (w_take),
        .o_rdata (w_head),
        .o_empty (w_q_empty)
    );

    // Back: output register, refilled while the current word is popped.
    zsmd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_head           (w_head),
        .i_head_valid     (!w_q_empty),
        .o_take           (w_take),
        .i_pop            (pop),
        .o_empty          (empty),
        .o_event_res      (o_event_res),
        .o_period_a       (o_period_a),
        .o_period_b       (o_period_b),
        .o_period_c       (o_period_c),
        .o_period_d       (o_period_d),
        .o_direction_bits (o_direction_bits)
    );

endmodule

### rtl/zsmd_checker.sv
// ----------------------------------------------------------------------------
// zsmd_checker
// Port-level checks of the deframer, bound to the top level.
// ----------------------------------------------------------------------------
`include "zero_sync_motor_command_deframer_core_macros.svh"

module zsmd_checker
    import zsmd_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                push,
    input  logic                full,
    input  logic                empty,
    input  logic                pop,
    input  logic [EVENT_W-1:0]  o_event_res,
    input  logic [PERIOD_W-1:0] o_period_a,
    input  logic [PERIOD_W-1:0] o_period_b,
    input  logic [PERIOD_W-1:0] o_period_c,
    input  logic [PERIOD_W-1:0] o_period_d,
    input  logic [DIR_W-1:0]    o_direction_bits
);

    // held event, period_a and direction bits must not change while stalled
    `ZSMD_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, !empty && !pop, !empty && $stable(o_event_res) && $stable(o_period_a) && $stable(o_direction_bits))

    // only the three defined event codes
    `ZSMD_ASSERT_NOW(a_event_code, i_clk, i_rst_n, !empty, (o_event_res == EV_ACCEPT) || (o_event_res == EV_CHECK_ERR) || (o_event_res == EV_LINK_LOST))

    // fault events carry a cleared payload
    `ZSMD_ASSERT_NOW(a_fault_zero, i_clk, i_rst_n, !empty && (o_event_res != EV_ACCEPT), (o_period_a == '0) && (o_period_b == '0) && (o_period_c == '0) && (o_period_d == '0) && (o_direction_bits == '0))

    // queue cannot fill up without input traffic
    `ZSMD_ASSERT_NEXT(a_full_needs_push, i_clk, i_rst_n, !full && !push, !full)

endmodule

bind zero_sync_motor_command_deframer_core zsmd_checker u_zsmd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .push             (push),
    .full             (full),
    .empty            (empty),
    .pop              (pop),
    .o_event_res      (o_event_res),
    .o_period_a       (o_period_a),
    .o_period_b       (o_period_b),
    .o_period_c       (o_period_c),
    .o_period_d       (o_period_d),
    .o_direction_bits (o_direction_bits)
);
